/* sv/dwh_pkg.sv */
// Shared types and constants of the DMA window hole allocator.
// No dependencies.
package dwh_pkg;

  localparam int unsigned MaxHolesDef    = 64;
  localparam int unsigned PageShiftDef   = 13;
  localparam int unsigned WindowPagesDef = 256;
  localparam logic [31:0] WindowBaseDef  = 32'd267386880;

  localparam int unsigned LenW       = 22;
  localparam logic [21:0] DefaultLen = 22'h000800;
  localparam logic [31:0] UseMax     = 32'h003FFFFF;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNull    = 3'd1,
    StNoFit   = 3'd2,
    StExhaust = 3'd3,
    StUnrec   = 3'd4
  } status_e;

  typedef enum logic {
    CmdAlloc = 1'b0,
    CmdFree  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic        cmd;
    logic [31:0] kernel_addr;
    logic [21:0] length;
    logic [21:0] alignment;
    logic [31:0] bus_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] result_addr;
    logic [2:0]  status;
  } rsp_t;

endpackage

/* sv/dwh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* sv/dma_window_hole_allocator.sv */
// Top level of the DMA window hole allocator: request sequencer over the hole list RAM
// and the per-page length RAM. Depends on dwh_pkg and dwh_ram.
//
// One request at a time; busy_o is high from acceptance through the result strobe. The
// hole list is walked one entry at a time: a read state, then a check state per entry
// (one RAM read port, registered read data). An allocate takes the first hole that fits;
// a free merges into an adjacent hole if found, else runs a merge pass when the list is
// full and shifts the list down for a head insert. Removing an exactly fitting hole shifts
// the entries after it up. SInit writes the initial hole after reset, before any request.
// The result is shown for one cycle on rsp_o with done_o high and cannot be held off.
module dma_window_hole_allocator #(
  parameter int unsigned MAX_HOLES    = dwh_pkg::MaxHolesDef,
  parameter int unsigned PAGE_SHIFT   = dwh_pkg::PageShiftDef,
  parameter int unsigned WINDOW_PAGES = dwh_pkg::WindowPagesDef,
  parameter logic [31:0] WINDOW_BASE  = dwh_pkg::WindowBaseDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dwh_pkg::req_t req_i,
  output logic          done_o,
  output dwh_pkg::rsp_t rsp_o
);

  import dwh_pkg::*;

  localparam int unsigned IW = $clog2(MAX_HOLES);
  localparam int unsigned CW = $clog2(MAX_HOLES + 1);
  localparam int unsigned PW = $clog2(WINDOW_PAGES);
  localparam logic [31:0] Pg     = 32'(1) << PAGE_SHIFT;
  localparam logic [31:0] PgMask = ~(Pg - 32'd1);
  localparam logic [31:0] WinEnd =
    32'(64'(WINDOW_BASE) + (64'(WINDOW_PAGES) << PAGE_SHIFT));
  localparam logic [CW-1:0] CntMax = CW'(MAX_HOLES);
  localparam logic [CW-1:0] One    = CW'(1);

  typedef enum logic [3:0] {
    SInit, SIdle, SARd, SAChk, SRmRd, SRmWr, SFPg, SFRd, SFChk,
    SMgRd, SMgChk, SMgEnd, SInRd, SInWr, SInHead, SDone
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, w_q, w_d;
  logic [31:0] len_q, len_d, align_q, align_d, baddr_q, baddr_d;
  logic [PAGE_SHIFT-1:0] off_q, off_d;
  logic [LenW-1:0] ulen_q, ulen_d;
  logic [PW-1:0] pidx_q, pidx_d;
  logic [31:0] ps_q, ps_d, pe_q, pe_d;
  logic have_q, have_d;
  logic [31:0] res_q, res_d;
  logic [2:0] st_q, st_d;
  logic [WINDOW_PAGES-1:0] vld_q, vld_d;

  logic h_we;
  logic [IW-1:0] h_waddr, h_raddr;
  logic [63:0] h_wdata, h_rdata;
  logic p_we;
  logic [PW-1:0] p_waddr, p_raddr;
  logic [LenW-1:0] p_wdata, p_rdata;

  dwh_ram #(.WIDTH(64), .DEPTH(MAX_HOLES)) u_hole_ram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  dwh_ram #(.WIDTH(LenW), .DEPTH(WINDOW_PAGES)) u_page_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  logic [31:0] hs, he, size, need, base, bidx, fidx, l0, a0, wm1;
  logic [CW-1:0] i_nx;
  logic go_nf;

  assign hs   = h_rdata[63:32];
  assign he   = h_rdata[31:0];
  assign size = he - hs;
  assign i_nx = i_q + One;
  assign fidx = (req_i.bus_addr - WINDOW_BASE) >> PAGE_SHIFT;
  assign l0   = (req_i.length == '0) ? {10'd0, DefaultLen} : {10'd0, req_i.length};
  assign a0   = {10'd0, req_i.alignment};
  assign wm1  = 32'(w_q) - 32'd1;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; i_d = i_q; w_d = w_q;
    len_d = len_q; align_d = align_q; baddr_d = baddr_q; off_d = off_q;
    ulen_d = ulen_q; pidx_d = pidx_q;
    ps_d = ps_q; pe_d = pe_q; have_d = have_q;
    res_d = res_q; st_d = st_q; vld_d = vld_q;
    h_we = 1'b0; h_waddr = i_q[IW-1:0]; h_wdata = h_rdata; h_raddr = i_q[IW-1:0];
    p_we = 1'b0; p_waddr = pidx_q; p_raddr = fidx[PW-1:0];
    need = len_q;
    if (align_q > Pg) begin
      need = len_q + ((he - len_q) & (align_q - 32'd1));
    end
    base = he - need;
    bidx = '0;
    p_wdata = need[LenW-1:0];
    go_nf = 1'b0;

    case (state_q)
      SInit: begin
        h_we = 1'b1; h_waddr = '0; h_wdata = {WINDOW_BASE, WinEnd};
        cnt_d = One;
        state_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          res_d = '0;
          i_d = '0;
          if (req_i.cmd == CmdAlloc) begin
            off_d = req_i.kernel_addr[PAGE_SHIFT-1:0];
            len_d = (l0 + 32'(req_i.kernel_addr[PAGE_SHIFT-1:0]) + Pg - 32'd1) & PgMask;
            align_d = (a0 == '0) ? Pg : ((a0 + Pg - 32'd1) & PgMask);
            if (req_i.kernel_addr == '0) begin
              st_d = StNull; state_d = SDone;
            end else if (cnt_q == '0) begin
              st_d = StNoFit; state_d = SDone;
            end else begin
              state_d = SARd;
            end
          end else begin
            baddr_d = req_i.bus_addr & PgMask;
            pidx_d = fidx[PW-1:0];
            if (fidx >= 32'(WINDOW_PAGES)) begin
              st_d = StUnrec; state_d = SDone;
            end else begin
              state_d = SFPg;
            end
          end
        end
      end
      SARd: state_d = SAChk;
      SAChk: begin
        if (need <= UseMax && size >= need) begin
          if (size != need) begin
            h_we = 1'b1; h_wdata = {hs, base};
          end else begin
            base = hs;
          end
          bidx = (base - WINDOW_BASE) >> PAGE_SHIFT;
          if (bidx < 32'(WINDOW_PAGES)) begin
            p_we = 1'b1; p_waddr = bidx[PW-1:0];
            vld_d[bidx[PW-1:0]] = 1'b1;
          end
          res_d = base + 32'(off_q);
          st_d = StOk;
          if (size != need || i_nx == cnt_q) begin
            if (size == need) cnt_d = cnt_q - One;
            state_d = SDone;
          end else begin
            i_d = i_nx; state_d = SRmRd;
          end
        end else begin
          i_d = i_nx;
          if (i_nx == cnt_q) begin
            st_d = StNoFit; state_d = SDone;
          end else begin
            state_d = SARd;
          end
        end
      end
      SRmRd: state_d = SRmWr;
      SRmWr: begin
        h_we = 1'b1; h_waddr = IW'(i_q - One);
        i_d = i_nx;
        if (i_nx == cnt_q) begin
          cnt_d = cnt_q - One; state_d = SDone;
        end else begin
          state_d = SRmRd;
        end
      end
      SFPg: begin
        if (!vld_q[pidx_q]) begin
          st_d = StUnrec; state_d = SDone;
        end else begin
          ulen_d = p_rdata;
          if (cnt_q == '0) go_nf = 1'b1;
          else state_d = SFRd;
        end
      end
      SFRd: state_d = SFChk;
      SFChk: begin
        if (he == baddr_q) begin
          h_we = 1'b1; h_wdata = {hs, he + 32'(ulen_q)};
          vld_d[pidx_q] = 1'b0; st_d = StOk; state_d = SDone;
        end else if (hs == baddr_q + 32'(ulen_q)) begin
          h_we = 1'b1; h_wdata = {baddr_q, he};
          vld_d[pidx_q] = 1'b0; st_d = StOk; state_d = SDone;
        end else begin
          i_d = i_nx;
          if (i_nx == cnt_q) go_nf = 1'b1;
          else state_d = SFRd;
        end
      end
      SMgRd: state_d = SMgChk;
      SMgChk: begin
        if (have_q && he == ps_q) begin
          ps_d = hs;
        end else begin
          if (have_q) begin
            h_we = 1'b1; h_waddr = wm1[IW-1:0]; h_wdata = {ps_q, pe_q};
          end
          ps_d = hs; pe_d = he; have_d = 1'b1;
          w_d = w_q + One;
        end
        i_d = i_nx;
        state_d = (i_nx == cnt_q) ? SMgEnd : SMgRd;
      end
      SMgEnd: begin
        if (have_q) begin
          h_we = 1'b1; h_waddr = wm1[IW-1:0]; h_wdata = {ps_q, pe_q};
        end
        if (w_q == cnt_q) begin
          st_d = StExhaust; state_d = SDone;
        end else begin
          cnt_d = w_q;
          if (w_q == '0) begin
            state_d = SInHead;
          end else begin
            i_d = w_q - One; state_d = SInRd;
          end
        end
      end
      SInRd: state_d = SInWr;
      SInWr: begin
        h_we = 1'b1; h_waddr = IW'(i_nx);
        if (i_q == '0) begin
          state_d = SInHead;
        end else begin
          i_d = i_q - One; state_d = SInRd;
        end
      end
      SInHead: begin
        h_we = 1'b1; h_waddr = '0; h_wdata = {baddr_q, baddr_q + 32'(ulen_q)};
        cnt_d = cnt_q + One;
        vld_d[pidx_q] = 1'b0;
        st_d = StOk; state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase

    if (go_nf) begin
      if (cnt_q >= CntMax) begin
        i_d = '0; w_d = '0; have_d = 1'b0; state_d = SMgRd;
      end else if (cnt_q == '0) begin
        state_d = SInHead;
      end else begin
        i_d = cnt_q - One; state_d = SInRd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      cnt_q   <= '0;
      i_q     <= '0;
      w_q     <= '0;
      have_q  <= 1'b0;
      vld_q   <= '0;
      st_q    <= StOk;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      w_q     <= w_d;
      have_q  <= have_d;
      vld_q   <= vld_d;
      st_q    <= st_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    align_q <= align_d;
    baddr_q <= baddr_d;
    off_q   <= off_d;
    ulen_q  <= ulen_d;
    pidx_q  <= pidx_d;
    ps_q    <= ps_d;
    pe_q    <= pe_d;
  end

  assign busy_o            = (state_q != SIdle);
  assign done_o            = (state_q == SDone);
  assign rsp_o.result_addr = res_q;
  assign rsp_o.status      = st_q;

endmodule
